### hw/rtl/xad_pkg.sv
package xad_pkg;

  localparam int UNIT_CODES   = 28;
  localparam int PAIR_RESULTS = 56;
  localparam int CODES_W      = 56;
  localparam int UNIT_W       = 2 * CODES_W;
  localparam int NIB_W        = 4;
  localparam int RANGE_W      = 4;
  localparam int FILT_W       = 2;
  localparam int ACC_W        = 32;
  localparam int PCM_W        = 16;
  localparam int COEF_W       = 18;
  localparam int PROD_W       = COEF_W + ACC_W;
  localparam int IDX_W        = $clog2(PAIR_RESULTS);

  // APB register map: one 32-bit register per word
  localparam int APB_DATA_W = 32;
  localparam int APB_ADDR_W = 3;
  localparam logic REG_STEREO = 1'b0;

  localparam logic [RANGE_W-1:0] RANGE_UNITY = RANGE_W'(12);
  localparam logic [IDX_W-1:0]   IDX_LAST    = IDX_W'(PAIR_RESULTS - 1);
  localparam logic [IDX_W-1:0]   IDX_UNIT_B  = IDX_W'(UNIT_CODES);

  localparam logic signed [PCM_W:0] PCM_MAX = (PCM_W+1)'(32767);
  localparam logic signed [PCM_W:0] PCM_MIN = -(PCM_W+1)'(32768);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MUL0,
    ST_MUL1,
    ST_SUM
  } xad_state_t;

  typedef struct packed {
    logic               clear;
    logic               acc_load;
    logic               mul_k1;
    logic               commit;
    logic               right;
    logic               last;
    logic [FILT_W-1:0]  filt;
    logic [RANGE_W-1:0] range;
    logic [NIB_W-1:0]   code;
  } xad_ctl_t;

  function automatic logic signed [COEF_W-1:0] coef0(input logic [FILT_W-1:0] f);
    logic signed [COEF_W-1:0] k;
    case (f)
      2'd0:    k = '0;
      2'd1:    k = COEF_W'(18'sh0F000);
      2'd2:    k = COEF_W'(18'sh1CC00);
      2'd3:    k = COEF_W'(18'sh18800);
      default: k = '0;
    endcase
    return k;
  endfunction

  function automatic logic signed [COEF_W-1:0] coef1(input logic [FILT_W-1:0] f);
    logic signed [COEF_W-1:0] k;
    case (f)
      2'd0:    k = '0;
      2'd1:    k = '0;
      2'd2:    k = -COEF_W'(18'sd53248);
      2'd3:    k = -COEF_W'(18'sd56320);
      default: k = '0;
    endcase
    return k;
  endfunction

endpackage

### hw/rtl/xad_in_if.sv
interface xad_in_if import xad_pkg::*; ();
  logic                   valid;
  logic                   ready;
  logic [RANGE_W-1:0]     range_a;
  logic [FILT_W-1:0]      filter_a;
  logic [CODES_W-1:0]     codes_a_low;
  logic [CODES_W-1:0]     codes_a_high;
  logic [RANGE_W-1:0]     range_b;
  logic [FILT_W-1:0]      filter_b;
  logic [CODES_W-1:0]     codes_b_low;
  logic [CODES_W-1:0]     codes_b_high;
  logic                   restart;

  modport source (
    output valid, range_a, filter_a, codes_a_low, codes_a_high,
           range_b, filter_b, codes_b_low, codes_b_high, restart,
    input  ready
  );
  modport sink (
    input  valid, range_a, filter_a, codes_a_low, codes_a_high,
           range_b, filter_b, codes_b_low, codes_b_high, restart,
    output ready
  );
endinterface

### hw/rtl/xad_out_if.sv
interface xad_out_if import xad_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic signed [PCM_W-1:0] pcm_sample;
  logic                    channel;
  logic                    last_of_item;

  modport source (
    output valid, pcm_sample, channel, last_of_item,
    input  ready
  );
  modport sink (
    input  valid, pcm_sample, channel, last_of_item,
    output ready
  );
endinterface

### hw/rtl/xad_seq.sv
module xad_seq import xad_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               stereo_mode,
  input  logic               in_fire,
  input  logic [RANGE_W-1:0] range_a,
  input  logic [FILT_W-1:0]  filter_a,
  input  logic [CODES_W-1:0] codes_a_low,
  input  logic [CODES_W-1:0] codes_a_high,
  input  logic [RANGE_W-1:0] range_b,
  input  logic [FILT_W-1:0]  filter_b,
  input  logic [CODES_W-1:0] codes_b_low,
  input  logic [CODES_W-1:0] codes_b_high,
  input  logic               restart,
  input  logic               out_free,
  output logic               idle,
  output xad_ctl_t           ctl
);

  xad_state_t         state, state_next;
  logic [IDX_W-1:0]   idx;
  logic [UNIT_W-1:0]  codes_a, codes_b;
  logic [RANGE_W-1:0] rng_a, rng_b;
  logic [FILT_W-1:0]  flt_a, flt_b;
  logic               use_b;

  // stereo alternates units sample by sample; mono runs a then b
  assign use_b = stereo_mode ? idx[0] : (idx >= IDX_UNIT_B);

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: if (in_fire) state_next = ST_MUL0;
      ST_MUL0: state_next = ST_MUL1;
      ST_MUL1: state_next = ST_SUM;
      ST_SUM:  if (out_free) state_next = (idx == IDX_LAST) ? ST_IDLE : ST_MUL0;
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    ctl          = '0;
    ctl.clear    = in_fire & restart;
    ctl.right    = stereo_mode & idx[0];
    ctl.last     = (idx == IDX_LAST);
    ctl.filt     = use_b ? flt_b : flt_a;
    ctl.range    = use_b ? rng_b : rng_a;
    ctl.code     = use_b ? codes_b[NIB_W-1:0] : codes_a[NIB_W-1:0];
    idle         = 1'b0;
    case (state)
      ST_IDLE: idle = 1'b1;
      ST_MUL0: ctl.acc_load = 1'b1;
      ST_MUL1: ctl.mul_k1 = 1'b1;
      ST_SUM:  ctl.commit = out_free;
      default: idle = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      idx   <= '0;
    end else begin
      state <= state_next;
      if (in_fire) begin
        idx <= '0;
      end else if (ctl.commit) begin
        idx <= idx + IDX_W'(1);
      end
    end
  end

  // payload: load on accept, shift the used unit down one nibble per sample
  always_ff @(posedge clk) begin
    if (in_fire) begin
      codes_a <= {codes_a_high, codes_a_low};
      codes_b <= {codes_b_high, codes_b_low};
      rng_a   <= range_a;
      rng_b   <= range_b;
      flt_a   <= filter_a;
      flt_b   <= filter_b;
    end else if (ctl.commit) begin
      if (use_b) begin
        codes_b <= {{NIB_W{1'b0}}, codes_b[UNIT_W-1:NIB_W]};
      end else begin
        codes_a <= {{NIB_W{1'b0}}, codes_a[UNIT_W-1:NIB_W]};
      end
    end
  end

endmodule

### hw/rtl/xad_mac.sv
module xad_mac import xad_pkg::*; (
  input  logic                    clk,
  input  logic                    rst,
  input  xad_ctl_t                ctl,
  output logic signed [PCM_W-1:0] pcm
);

  logic signed [ACC_W-1:0]  left_prev1, left_prev2, right_prev1, right_prev2;
  logic signed [ACC_W-1:0]  h1, h2, h_op;
  logic signed [COEF_W-1:0] k_op;
  logic signed [PROD_W-1:0] prod_full;
  logic signed [ACC_W-1:0]  prod, acc;
  logic signed [ACC_W-1:0]  nib32, scaled, add_a, add_b, sum;
  logic signed [ACC_W:0]    sum_x, half;

  assign h1 = ctl.right ? right_prev1 : left_prev1;
  assign h2 = ctl.right ? right_prev2 : left_prev2;

  // shared multiplier: K0*h1 first, then K1*h2
  assign k_op      = ctl.mul_k1 ? coef1(ctl.filt) : coef0(ctl.filt);
  assign h_op      = ctl.mul_k1 ? h2 : h1;
  assign prod_full = k_op * h_op;

  // ranges above unity turn into an arithmetic right shift (floor)
  always_comb begin
    nib32 = {{(ACC_W-NIB_W){ctl.code[NIB_W-1]}}, ctl.code};
    if (ctl.range <= RANGE_UNITY) begin
      scaled = nib32 <<< (RANGE_UNITY - ctl.range);
    end else begin
      scaled = nib32 >>> (ctl.range - RANGE_UNITY);
    end
  end

  // shared adder: seed with the doubled code, then fold in each product
  assign add_a = ctl.acc_load ? '0 : acc;
  assign add_b = ctl.acc_load ? (scaled <<< 1) : prod;
  assign sum   = add_a + add_b;

  // halve toward zero, then clamp
  assign sum_x = {sum[ACC_W-1], sum};
  assign half  = $signed(sum_x + (ACC_W+1)'(sum[ACC_W-1])) >>> 1;

  always_comb begin
    if (half > PCM_MAX) begin
      pcm = PCM_MAX[PCM_W-1:0];
    end else if (half < PCM_MIN) begin
      pcm = PCM_MIN[PCM_W-1:0];
    end else begin
      pcm = half[PCM_W-1:0];
    end
  end

  // hold the product through the sum step, however long it stalls
  always_ff @(posedge clk) begin
    if (ctl.acc_load || ctl.mul_k1) begin
      prod <= prod_full[ACC_W+15:16];
    end
    if (ctl.acc_load || ctl.mul_k1) begin
      acc <= sum;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || ctl.clear) begin
      left_prev1  <= '0;
      left_prev2  <= '0;
      right_prev1 <= '0;
      right_prev2 <= '0;
    end else if (ctl.commit) begin
      if (ctl.right) begin
        right_prev2 <= right_prev1;
        right_prev1 <= sum;
      end else begin
        left_prev2 <= left_prev1;
        left_prev1 <= sum;
      end
    end
  end

endmodule

### hw/rtl/xa_adpcm_unit_decoder.sv
// Channel   Dir  Handshake            Beat
// unit_pair in   valid/ready          two 28-code ADPCM units, ranges, filters, restart
// pcm       out  valid/ready          one 16-bit sample, channel, last_of_item
// APB       in   psel/penable, pready register 0 (byte 0): stereo_mode
//
// Each sample runs on one multiplier and one adder, in order: K0*h1, K1*h2, sum.
// A pair of units gives 56 samples; a new pair is taken only once the sequencer
// is idle again after the last sample of the previous pair.
// rst is synchronous; it clears the histories, the mode and the sequencer.
// A stalled pcm beat holds the sequencer in its sum step; the next pair is taken
// while the last sample of the previous pair still waits in the output register.
module xa_adpcm_unit_decoder import xad_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output logic                  pready,
  xad_in_if.sink                unit_pair,
  xad_out_if.source             pcm
);

  logic                    stereo_mode;
  logic                    in_fire;
  logic                    seq_idle;
  logic                    out_free;
  logic                    out_valid;
  logic signed [PCM_W-1:0] pcm_next;
  xad_ctl_t                ctl;

  // register access: one word, index taken from the word address bit
  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_STEREO) ? APB_DATA_W'(stereo_mode) : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      stereo_mode <= 1'b0;
    end else if (psel && penable && pwrite && pready && paddr[2] == REG_STEREO) begin
      stereo_mode <= pwdata[0];
    end
  end

  // take a new pair only while the sequencer is idle
  assign unit_pair.ready = seq_idle;
  assign in_fire         = unit_pair.valid & seq_idle;

  // the output slot frees when empty or when its beat leaves this cycle
  assign out_free = !out_valid || pcm.ready;

  xad_seq u_seq (
    .clk          (clk),
    .rst          (rst),
    .stereo_mode  (stereo_mode),
    .in_fire      (in_fire),
    .range_a      (unit_pair.range_a),
    .filter_a     (unit_pair.filter_a),
    .codes_a_low  (unit_pair.codes_a_low),
    .codes_a_high (unit_pair.codes_a_high),
    .range_b      (unit_pair.range_b),
    .filter_b     (unit_pair.filter_b),
    .codes_b_low  (unit_pair.codes_b_low),
    .codes_b_high (unit_pair.codes_b_high),
    .restart      (unit_pair.restart),
    .out_free     (out_free),
    .idle         (seq_idle),
    .ctl          (ctl)
  );

  xad_mac u_mac (
    .clk (clk),
    .rst (rst),
    .ctl (ctl),
    .pcm (pcm_next)
  );

  // output register: load on commit, drop once the beat is taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ctl.commit) begin
      out_valid <= 1'b1;
    end else if (pcm.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.commit) begin
      pcm.pcm_sample   <= pcm_next;
      pcm.channel      <= ctl.right;
      pcm.last_of_item <= ctl.last;
    end
  end

  assign pcm.valid = out_valid;

`ifndef SYNTHESIS
  // a waiting beat is never overwritten
  assert property (@(posedge clk) disable iff (rst)
    (out_valid && !pcm.ready) |-> !ctl.commit)
    else $error("pcm beat overwritten while stalled");

  // the last sample of a pair returns the sequencer to idle
  assert property (@(posedge clk) disable iff (rst)
    (ctl.commit && ctl.last) |=> unit_pair.ready)
    else $error("sequencer not idle after last sample");

  // mono mode never writes a sample into the right history
  assert property (@(posedge clk) disable iff (rst)
    (ctl.commit && !stereo_mode) |-> !ctl.right)
    else $error("right channel used in mono mode");

  // no new pair is taken while samples are still being produced
  assert property (@(posedge clk) disable iff (rst)
    ctl.commit |-> !in_fire)
    else $error("pair accepted mid-decode");
`endif

endmodule
